// ----- src/sdf_pkg.sv -----
package sdf_pkg;

	// Header layout: message id, payload length, command word.
	localparam int HEADER_LEN = 8'h08;
	localparam int HDR_IDX_W  = $clog2(HEADER_LEN);

	// Configuration register map.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_TAG_PATTERN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_WORD_0  = 4'd1;

	// Default parameter values.
	localparam int DEF_TAG_BYTES     = 4;
	localparam int DEF_COMMAND_COUNT = 7;

	// Parser mode codes; the unused code behaves as tag search.
	localparam logic [1:0] MODE_TAG    = 2'd0;
	localparam logic [1:0] MODE_HEADER = 2'd1;
	localparam logic [1:0] MODE_DATA   = 2'd2;

	// Result kinds.
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef struct packed {
		logic        item_kind;
		logic [15:0] frame_id;
		logic [15:0] payload_length;
		logic [2:0]  command_index;
		logic [7:0]  payload_byte;
		logic        last;
	} result_t;

endpackage

// ----- src/sdf_cfg_regs.sv -----
module sdf_cfg_regs import sdf_pkg::*; #(
	parameter int COMMAND_COUNT = DEF_COMMAND_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output logic [31:0]          tag_pattern,
	output logic [31:0]          cmd_words [COMMAND_COUNT]
);

	logic [31:0] tag_pattern_q;
	logic [31:0] cmd_words_q [COMMAND_COUNT];

	// Writes to indexes past the implemented command words fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_pattern_q <= '0;
			for (int k = 0; k < COMMAND_COUNT; k++) begin
				cmd_words_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_TAG_PATTERN) begin
				tag_pattern_q <= cfg_data;
			end
			for (int k = 0; k < COMMAND_COUNT; k++) begin
				if (cfg_index == REG_CMD_WORD_0 + CFG_IDX_W'(k)) begin
					cmd_words_q[k] <= cfg_data;
				end
			end
		end
	end

	assign tag_pattern = tag_pattern_q;
	assign cmd_words   = cmd_words_q;

endmodule

// ----- src/sdf_parser.sv -----
module sdf_parser import sdf_pkg::*; #(
	parameter int TAG_BYTES     = DEF_TAG_BYTES,
	parameter int COMMAND_COUNT = DEF_COMMAND_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] tag_pattern,
	input  logic [31:0] cmd_words [COMMAND_COUNT],
	output logic        res_valid,
	output result_t     res
);

	logic [1:0]  mode_q, mode_d;
	logic [15:0] cursor_q, cursor_d, cursor_inc;
	logic [7:0]  hdr_q [HEADER_LEN];
	logic        hdr_we;
	logic [15:0] held_id_q, held_id_d;
	logic [15:0] held_len_q, held_len_d;
	logic [2:0]  held_cmd_q, held_cmd_d;
	logic [31:0] cmd_word;
	logic        cmd_hit;
	logic [2:0]  cmd_idx;
	logic [1:0]  tag_pos;
	logic [7:0]  tag_want;
	logic        res_gen;
	logic        res_kind;
	logic [7:0]  res_byte;
	logic        res_last;

	// The last command byte arrives with this beat, the rest is stored.
	assign cmd_word = {rx_byte, hdr_q[6], hdr_q[5], hdr_q[4]};

	// Lowest matching index wins, so scan from the top down.
	always_comb begin
		cmd_hit = 1'b0;
		cmd_idx = '0;
		for (int k = COMMAND_COUNT - 1; k >= 0; k--) begin
			if (cmd_words[k] == cmd_word) begin
				cmd_hit = 1'b1;
				cmd_idx = 3'(k);
			end
		end
	end

	assign tag_pos    = cursor_q[1:0];
	assign tag_want   = tag_pattern[8*tag_pos +: 8];
	assign cursor_inc = cursor_q + 16'd1;

	always_comb begin
		mode_d     = mode_q;
		cursor_d   = cursor_q;
		held_id_d  = held_id_q;
		held_len_d = held_len_q;
		held_cmd_d = held_cmd_q;
		hdr_we     = 1'b0;
		res_gen    = 1'b0;
		res_kind   = KIND_HEADER;
		res_byte   = '0;
		res_last   = 1'b0;
		case (mode_q)
			MODE_DATA: begin
				res_gen  = 1'b1;
				res_kind = KIND_PAYLOAD;
				res_byte = rx_byte;
				res_last = (cursor_inc >= held_len_q);
				if (res_last) begin
					mode_d   = MODE_TAG;
					cursor_d = '0;
				end else begin
					cursor_d = cursor_inc;
				end
			end
			MODE_HEADER: begin
				hdr_we = 1'b1;
				if (cursor_q == 16'(HEADER_LEN - 1)) begin
					cursor_d = '0;
					if (!cmd_hit) begin
						mode_d = MODE_TAG;
					end else begin
						held_id_d  = {hdr_q[1], hdr_q[0]};
						held_len_d = {hdr_q[3], hdr_q[2]};
						held_cmd_d = cmd_idx;
						res_gen    = 1'b1;
						res_last   = (held_len_d == 16'd0);
						mode_d     = res_last ? MODE_TAG : MODE_DATA;
					end
				end else begin
					cursor_d = cursor_inc;
				end
			end
			default: begin
				mode_d = MODE_TAG;
				if (rx_byte == tag_want) begin
					if ({14'd0, tag_pos} + 16'd1 >= 16'(TAG_BYTES)) begin
						mode_d   = MODE_HEADER;
						cursor_d = '0;
					end else begin
						cursor_d = {14'd0, tag_pos} + 16'd1;
					end
				end else begin
					cursor_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_TAG;
			cursor_q   <= '0;
			held_id_q  <= '0;
			held_len_q <= '0;
			held_cmd_q <= '0;
		end else if (take) begin
			mode_q     <= mode_d;
			cursor_q   <= cursor_d;
			held_id_q  <= held_id_d;
			held_len_q <= held_len_d;
			held_cmd_q <= held_cmd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && hdr_we) begin
			hdr_q[cursor_q[HDR_IDX_W-1:0]] <= rx_byte;
		end
	end

	assign res_valid          = take && res_gen;
	assign res.item_kind      = res_kind;
	assign res.frame_id       = held_id_d;
	assign res.payload_length = held_len_d;
	assign res.command_index  = held_cmd_d;
	assign res.payload_byte   = res_byte;
	assign res.last           = res_last;

endmodule

// ----- src/sdf_out_reg.sv -----
module sdf_out_reg import sdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t din,
	input  logic    out_ready,
	output logic    out_valid,
	output logic    space,
	output result_t dout
);

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	// Room for a new result when empty or when the held one leaves now.
	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign dout      = data_q;

endmodule

// ----- src/serial_packet_deframer_top.sv -----
//  Channel | Handshake  | Fields in a beat
//  --------+------------+------------------------------------------------------------------
//  input   | in_*       | rx_byte
//  output  | out_*      | item_kind frame_id payload_length command_index payload_byte last
//  config  | cfg_*      | cfg_index cfg_data
//
//  Each input beat is parsed in the cycle it is accepted; a result it causes sits in the
//  output register from the next cycle on, so one byte per clock is sustained while out_ready stays high.
//  in_ready is low only while a result is held and out_ready is low.
//  Reset returns the parser to tag search and clears the configuration and held fields;
//  the header byte store is not reset because every byte is written before it is read.
//  Configuration writes are always taken.
module serial_packet_deframer_top import sdf_pkg::*; #(
	parameter int TAG_BYTES     = DEF_TAG_BYTES,
	parameter int COMMAND_COUNT = DEF_COMMAND_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 item_kind,
	output logic [15:0]          frame_id,
	output logic [15:0]          payload_length,
	output logic [2:0]           command_index,
	output logic [7:0]           payload_byte,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic        take;
	logic        res_valid;
	result_t     res;
	result_t     out_data;
	logic        space;
	logic [31:0] tag_pattern;
	logic [31:0] cmd_words [COMMAND_COUNT];

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;

	sdf_cfg_regs #(
		.COMMAND_COUNT(COMMAND_COUNT)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tag_pattern(tag_pattern),
		.cmd_words  (cmd_words)
	);

	// A beat is taken whenever the output register can absorb a result, even
	// if this particular byte turns out to produce none.
	assign in_ready = space;
	assign take     = in_valid && in_ready;

	// The parser walks tag search, header collection and payload streaming.
	// Its state only moves on an accepted beat.
	sdf_parser #(
		.TAG_BYTES    (TAG_BYTES),
		.COMMAND_COUNT(COMMAND_COUNT)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx_byte),
		.tag_pattern(tag_pattern),
		.cmd_words  (cmd_words),
		.res_valid  (res_valid),
		.res        (res)
	);

	sdf_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.din      (res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.space    (space),
		.dout     (out_data)
	);

	assign item_kind      = out_data.item_kind;
	assign frame_id       = out_data.frame_id;
	assign payload_length = out_data.payload_length;
	assign command_index  = out_data.command_index;
	assign payload_byte   = out_data.payload_byte;
	assign last           = out_data.last;

endmodule

// ----- src/sdf_checker.sv -----
module sdf_checker import sdf_pkg::*; #(
	parameter int COMMAND_COUNT = DEF_COMMAND_COUNT
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [7:0]           rx_byte,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 item_kind,
	input logic [15:0]          frame_id,
	input logic [15:0]          payload_length,
	input logic [2:0]           command_index,
	input logic [7:0]           payload_byte,
	input logic                 last,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]          cfg_data
);

	// A header result closes its packet exactly when the length is zero.
	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_HEADER |-> last == (payload_length == 16'd0))
		else $error("header last flag disagrees with payload length");

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(command_index) < COMMAND_COUNT)
		else $error("command index beyond configured words");

	// After a result that does not close a packet, the next result shown in
	// the following cycle is a payload byte of that same packet.
	a_pkt_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) ##1 out_valid
		|-> item_kind == KIND_PAYLOAD && frame_id == $past(frame_id))
		else $error("packet continuation broken");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_id)
			&& $stable(payload_byte) && $stable(last) && $stable(item_kind))
		else $error("held result changed");

endmodule

bind serial_packet_deframer_top sdf_checker #(
	.COMMAND_COUNT(COMMAND_COUNT)
) u_sdf_checker (.*);
